FILE: src/plkf_pkg.sv
package plkf_pkg;

    localparam int NUM_TABLES      = 6;
    localparam int SCALE_FRAC_BITS = 8;

    localparam logic [15:0] SCALE_DEFAULT = 16'(((1 << SCALE_FRAC_BITS) + 5) / 10);

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_EVAL   = 1'b1;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

    localparam logic [2:0] CH_RED     = 3'd0;
    localparam logic [2:0] CH_GREEN   = 3'd1;
    localparam logic [2:0] CH_BLUE    = 3'd2;
    localparam logic [2:0] CH_ALPHA   = 3'd3;
    localparam logic [2:0] CH_SCALE_X = 3'd4;
    localparam logic [2:0] CH_SCALE_Y = 3'd5;

    localparam int DIV_NUM_W = 32;
    localparam int DIV_DEN_W = 16;

    typedef struct packed {
        logic [15:0]        position;
        logic signed [15:0] value;
    } t_key;

endpackage

FILE: src/plkf_key_mem.sv
module plkf_key_mem
    import plkf_pkg::*;
#(
    parameter int DEPTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  t_key                     i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output t_key                     o_rdata
);

    t_key r_mem [DEPTH];
    t_key r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/plkf_div.sv
module plkf_div
    import plkf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic                 o_done,
    output logic [DIV_NUM_W-1:0] o_quo
);

    localparam int STEPS = 2;
    localparam int ITERS = DIV_NUM_W / STEPS;
    localparam int IW    = $clog2(ITERS);

    logic                 r_busy;
    logic                 r_done;
    logic [IW-1:0]        r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W-1:0] n_rem;
    logic [DIV_NUM_W-1:0] n_quo;

    // two restoring steps a cycle
    always_comb begin
        logic [DIV_DEN_W:0] sh;
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < STEPS; k++) begin
            sh    = {n_rem, n_quo[DIV_NUM_W-1]};
            n_quo = {n_quo[DIV_NUM_W-2:0], 1'b0};
            if (sh >= {1'b0, r_den}) begin
                sh       = sh - {1'b0, r_den};
                n_quo[0] = 1'b1;
            end
            n_rem = sh[DIV_DEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt + IW'(1);
                if (r_cnt == IW'(ITERS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> i_den != '0)
        else $error("divider started with zero divisor");

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while running");

endmodule

FILE: src/piecewise_linear_keyframe_interp.sv
// Piecewise-linear keyframe evaluator with six tables (red, green, blue, alpha,
// scale x, scale y) of up to MAX_STAGES keyframes each, held in one synchronous
// memory. An item is taken when start is high and busy is low; its result word
// appears for exactly one cycle with o_done and cannot be held off. For an
// append o_done follows in the next cycle and busy stays low. An evaluate walks
// the six tables in turn, one keyframe read a cycle from the memory port while
// scanning, then for a matching interval a multiply state and a 2-bit a cycle
// divider; an evaluate ends sooner when tables are short or match early. busy
// falls in the cycle o_done is high, so the next item can be taken there.
module piecewise_linear_keyframe_interp
    import plkf_pkg::*;
#(
    parameter int MAX_STAGES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_operation,
    input  logic [2:0]         i_channel,
    input  logic [15:0]        i_stage_position,
    input  logic signed [15:0] i_stage_value,
    input  logic [15:0]        i_life_fraction,
    output logic               o_done,
    output logic               o_status,
    output logic [7:0]         o_red,
    output logic [7:0]         o_green,
    output logic [7:0]         o_blue,
    output logic [7:0]         o_alpha,
    output logic signed [15:0] o_scale_x,
    output logic signed [15:0] o_scale_y
);

    localparam int DEPTH = NUM_TABLES * MAX_STAGES;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_STAGES + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;
    localparam logic [1:0] S_DIV  = 2'd3;

    function automatic logic [7:0] clamp_colour(input logic signed [17:0] v);
        if (v < 18'sd0) begin
            return 8'd0;
        end else if (v > 18'sd255) begin
            return 8'd255;
        end
        return v[7:0];
    endfunction

    function automatic logic [15:0] sat_scale(input logic signed [17:0] v);
        if (v < -18'sd32768) begin
            return 16'h8000;
        end else if (v > 18'sd32767) begin
            return 16'h7fff;
        end
        return v[15:0];
    endfunction

    logic [1:0]         r_state;
    logic               r_done;
    logic               r_status;
    logic [7:0]         r_red;
    logic [7:0]         r_green;
    logic [7:0]         r_blue;
    logic [7:0]         r_alpha;
    logic [15:0]        r_scale_x;
    logic [15:0]        r_scale_y;
    logic [CW-1:0]      r_count [NUM_TABLES];
    logic [2:0]         r_table;
    logic [15:0]        r_life;
    logic [CW-1:0]      r_ra;
    logic [CW-1:0]      r_rk;
    logic               r_rv;
    logic [15:0]        r_p0;
    logic signed [15:0] r_v0;
    logic [15:0]        r_dl;
    logic [15:0]        r_dvmag;
    logic               r_neg;
    logic [15:0]        r_den;
    logic [31:0]        r_mag;
    logic               r_div_go;

    logic [2:0]         cnt_idx;
    logic [CW-1:0]      cnt_rd;
    logic               accept;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    t_key               mem_wdata;
    logic [AW-1:0]      mem_raddr;
    t_key               cur;
    logic               issue;
    logic               few;
    logic               hit;
    logic               last;
    logic               same_pos;
    logic signed [16:0] dv;
    logic [16:0]        dv_abs;
    logic               div_done;
    logic [31:0]        div_quo;
    logic [17:0]        q_ext;
    logic               fin;
    logic               fin_hit;
    logic signed [17:0] fin_val;
    logic [7:0]         fin_col;
    logic [15:0]        fin_scl;

    assign accept  = start && (r_state == S_IDLE);
    assign cnt_idx = (r_state == S_IDLE) ? i_channel : r_table;
    assign cnt_rd  = (cnt_idx < 3'(NUM_TABLES)) ? r_count[cnt_idx] : '0;

    // append write
    assign mem_we    = accept && (i_operation == OP_APPEND) && (i_channel < 3'(NUM_TABLES))
                       && (cnt_rd < CW'(MAX_STAGES));
    assign mem_waddr = AW'(i_channel * MAX_STAGES) + AW'(cnt_rd);
    assign mem_wdata.position = i_stage_position;
    assign mem_wdata.value    = (i_channel <= CH_ALPHA)
                                ? {8'd0, clamp_colour({{2{i_stage_value[15]}}, i_stage_value})}
                                : i_stage_value;

    // scan reads
    assign issue     = (r_state == S_SCAN) && (r_ra < cnt_rd);
    assign mem_raddr = AW'(r_table * MAX_STAGES) + AW'(r_ra);

    plkf_key_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (cur)
    );

    plkf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_mag),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign few      = cnt_rd < CW'(2);
    assign hit      = r_rv && (r_rk != '0) && (r_p0 <= r_life) && (r_life <= cur.position);
    assign last     = r_rv && (r_rk == CW'(cnt_rd - CW'(1)));
    assign same_pos = cur.position == r_p0;
    assign dv       = {cur.value[15], cur.value} - {r_v0[15], r_v0};
    assign dv_abs   = dv[16] ? (17'd0 - dv) : dv;
    assign q_ext    = {2'b00, div_quo[15:0]};

    always_comb begin
        fin     = 1'b0;
        fin_hit = 1'b0;
        fin_val = {{2{r_v0[15]}}, r_v0};
        case (r_state)
            S_SCAN: begin
                if (few) begin
                    fin = 1'b1;
                end else if (hit && same_pos) begin
                    fin     = 1'b1;
                    fin_hit = 1'b1;
                end else if (!hit && last) begin
                    fin = 1'b1;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    fin     = 1'b1;
                    fin_hit = 1'b1;
                    fin_val = {{2{r_v0[15]}}, r_v0} + (r_neg ? (18'd0 - q_ext) : q_ext);
                end
            end
            default: begin
                fin = 1'b0;
            end
        endcase
    end

    assign fin_col = fin_hit ? clamp_colour(fin_val) : 8'd0;
    assign fin_scl = fin_hit ? sat_scale(fin_val) : SCALE_DEFAULT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_done   <= 1'b0;
            r_rv     <= 1'b0;
            r_div_go <= 1'b0;
            r_table  <= '0;
            r_ra     <= '0;
            for (int t = 0; t < NUM_TABLES; t++) begin
                r_count[t] <= '0;
            end
        end else begin
            r_done   <= 1'b0;
            r_div_go <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_status <= ST_OK;
                        if (i_operation == OP_APPEND) begin
                            r_done    <= 1'b1;
                            r_red     <= '0;
                            r_green   <= '0;
                            r_blue    <= '0;
                            r_alpha   <= '0;
                            r_scale_x <= '0;
                            r_scale_y <= '0;
                            if (i_channel < 3'(NUM_TABLES)) begin
                                if (cnt_rd >= CW'(MAX_STAGES)) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_count[i_channel] <= cnt_rd + CW'(1);
                                end
                            end
                        end else begin
                            r_table <= CH_RED;
                            r_ra    <= '0;
                            r_rv    <= 1'b0;
                            r_life  <= i_life_fraction;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_rv <= issue;
                    r_rk <= r_ra;
                    if (issue) begin
                        r_ra <= r_ra + CW'(1);
                    end
                    if (r_rv && !hit) begin
                        r_p0 <= cur.position;
                        r_v0 <= cur.value;
                    end
                    if (!few && hit && !same_pos) begin
                        r_dl    <= r_life - r_p0;
                        r_dvmag <= dv_abs[15:0];
                        r_neg   <= dv[16];
                        r_den   <= cur.position - r_p0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_mag    <= r_dl * r_dvmag;
                    r_div_go <= 1'b1;
                    r_state  <= S_DIV;
                end
                S_DIV: begin
                    r_rv <= 1'b0;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (fin) begin
                case (r_table)
                    CH_RED:     r_red     <= fin_col;
                    CH_GREEN:   r_green   <= fin_col;
                    CH_BLUE:    r_blue    <= fin_col;
                    CH_ALPHA:   r_alpha   <= fin_col;
                    CH_SCALE_X: r_scale_x <= fin_scl;
                    default:    r_scale_y <= fin_scl;
                endcase
                r_rv <= 1'b0;
                r_ra <= '0;
                if (r_table == CH_SCALE_Y) begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end else begin
                    r_table <= r_table + 3'd1;
                    r_state <= S_SCAN;
                end
            end
        end
    end

    assign busy      = r_state != S_IDLE;
    assign o_done    = r_done;
    assign o_status  = r_status;
    assign o_red     = r_red;
    assign o_green   = r_green;
    assign o_blue    = r_blue;
    assign o_alpha   = r_alpha;
    assign o_scale_x = r_scale_x;
    assign o_scale_y = r_scale_y;

    a_item_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> o_done || busy)
        else $error("accepted word neither answered nor in progress");

    a_append_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_operation == OP_APPEND |=> o_done && !busy)
        else $error("append result not given in the next cycle");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status == ST_FULL |-> o_red == 8'd0 && o_green == 8'd0
            && o_blue == 8'd0 && o_alpha == 8'd0 && o_scale_x == 16'sd0
            && o_scale_y == 16'sd0)
        else $error("refused append carries non-zero result");

endmodule
